[rtl/assert_macros.svh]
// Assertion macros used by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/dtpn_pkg.sv]
// ----------------------------------------------------------------------------
// dtpn_pkg
// Shared types and constants of the direction-to-point normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package dtpn_pkg;
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_FRAC   = 30;
  localparam int OUT_BITS   = 32;
  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TARGET_X = 2'd0,
    REG_TARGET_Y = 2'd1,
    REG_TARGET_Z = 2'd2
  } cfg_reg_t;
endpackage
`default_nettype wire

[rtl/dtpn_stream_if.sv]
// ----------------------------------------------------------------------------
// dtpn_stream_if
// Valid/ready channel carrying a three-coordinate request.
// ----------------------------------------------------------------------------
`default_nettype none
interface dtpn_stream_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic [W-1:0] z;
  logic         flag;
  modport source (output valid, x, y, z, flag, input ready);
  modport sink   (input valid, x, y, z, flag, output ready);
endinterface
`default_nettype wire

[rtl/direction_to_point_normalize_core.sv]
// ----------------------------------------------------------------------------
// direction_to_point_normalize_core
// Unit vector from centroid to a configured target, signed Q2.30 out.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  cen       in   x/y/z centroid, COORD_BITS signed
//  dir       out  x/y/z unit Q2.30, flag = zero length
//  cfg       in   cfg_we, cfg_index, cfg_data
// One request per cycle while the pipeline advances; stages: difference, squares,
// sum, magnitude square, one stage per result bit of the search.
// Whole pipeline advances when the output is free or taken; a stall
// freezes every stage, nothing lost or repeated.
// Reset clears target registers and stage valid bits.
`default_nettype none
`include "assert_macros.svh"
module direction_to_point_normalize_core #(
  parameter int COORD_BITS = dtpn_pkg::COORD_BITS,
  parameter int FRAC_BITS  = dtpn_pkg::FRAC_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [dtpn_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [COORD_BITS-1:0] cfg_data,
  dtpn_stream_if.sink                cen,
  dtpn_stream_if.source              dir
);
  localparam int DB  = COORD_BITS + 1;
  localparam int SQB = 2*DB + 2;
  localparam int NB  = dtpn_pkg::OUT_FRAC + 1;
  localparam int LAT = NB + 4;
  localparam int OB  = dtpn_pkg::OUT_BITS;
  localparam int FRAC_UNUSED = FRAC_BITS; // cancels in the ratio

  logic [COORD_BITS-1:0] tx, ty, tz;
  logic [LAT-1:0] vld;
  logic adv;
  logic out_v;
  logic [OB-1:0] ox, oy, oz;
  logic oflag;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx <= '0; ty <= '0; tz <= '0;
    end else if (cfg_we) begin
      case (dtpn_pkg::cfg_reg_t'(cfg_index))
        dtpn_pkg::REG_TARGET_X: tx <= cfg_data;
        dtpn_pkg::REG_TARGET_Y: ty <= cfg_data;
        dtpn_pkg::REG_TARGET_Z: tz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv = !out_v || dir.ready;
  assign cen.ready = adv && (FRAC_UNUSED >= 0);

  // stage 1: differences
  logic signed [DB-1:0] d1 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0] <= $signed({tx[COORD_BITS-1], tx}) - $signed({cen.x[COORD_BITS-1], cen.x});
      d1[1] <= $signed({ty[COORD_BITS-1], ty}) - $signed({cen.y[COORD_BITS-1], cen.y});
      d1[2] <= $signed({tz[COORD_BITS-1], tz}) - $signed({cen.z[COORD_BITS-1], cen.z});
    end
  end
  // stage 2: magnitudes and squares
  logic [DB-1:0]  mag2 [3];
  logic [2*DB-1:0] sq2 [3];
  logic [2:0] neg2;
  for (genvar a = 0; a < 3; a++) begin : g_sq
    logic [DB-1:0] mg;
    assign mg = d1[a][DB-1] ? DB'(-d1[a]) : DB'(d1[a]);
    always_ff @(posedge clk) begin
      if (adv) begin
        mag2[a] <= mg;
        sq2[a]  <= (2*DB)'(mg) * (2*DB)'(mg);
        neg2[a] <= d1[a][DB-1];
      end
    end
  end
  // stage 3: sum
  logic [SQB-1:0] sum3;
  logic [DB-1:0]  mag3 [3];
  logic [2:0] neg3;
  always_ff @(posedge clk) begin
    if (adv) begin
      sum3 <= SQB'(sq2[0]) + SQB'(sq2[1]) + SQB'(sq2[2]);
      mag3 <= mag2;
      neg3 <= neg2;
    end
  end

  logic [NB-1:0] m [3];
  for (genvar a = 0; a < 3; a++) begin : g_lane
    dtpn_unit_lane #(.MAG_BITS(DB), .SQ_BITS(SQB)) u_lane (
      .clk(clk), .en(adv), .sumsq(sum3), .mag(mag3[a]), .m(m[a])
    );
  end
  // sign/zero side pipe, aligned with the lane output
  logic [3:0] side [NB+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= {sum3 == '0, neg3};
      for (int k = 1; k <= NB; k++) side[k] <= side[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[LAT-2:0], cen.valid};
  end
  assign out_v = vld[LAT-1];

  logic [3:0] sd;
  assign sd = side[NB];
  assign ox = sd[3] ? '0 : (sd[0] ? OB'(-(OB'(m[0]))) : OB'(m[0]));
  assign oy = sd[3] ? '0 : (sd[1] ? OB'(-(OB'(m[1]))) : OB'(m[1]));
  assign oz = sd[3] ? '0 : (sd[2] ? OB'(-(OB'(m[2]))) : OB'(m[2]));
  assign oflag = sd[3];

  assign dir.valid = out_v;
  assign dir.x = ox;
  assign dir.y = oy;
  assign dir.z = oz;
  assign dir.flag = oflag;

  `ASSERT_NEXT(a_stall_hold, clk, rst, dir.valid && !dir.ready, dir.valid && $stable(dir.x))
  `ASSERT_IMPL(a_zero_out, clk, rst, dir.valid && dir.flag, dir.x == '0 && dir.z == '0)
  `ASSERT_IMPL(a_ready, clk, rst, !dir.valid, cen.ready)
endmodule
`default_nettype wire

[rtl/dtpn_unit_lane.sv]
// ----------------------------------------------------------------------------
// dtpn_unit_lane
// Pipelined restoring bit search for one unit component: finds largest m with
// m^2 * s <= mag^2 * 2^60, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module dtpn_unit_lane #(
  parameter int MAG_BITS = 33,
  parameter int SQ_BITS  = 68
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [SQ_BITS-1:0]  sumsq,
  input  wire logic [MAG_BITS-1:0] mag,
  output logic [dtpn_pkg::OUT_FRAC:0] m
);
  localparam int NB = dtpn_pkg::OUT_FRAC + 1;
  localparam int RW = 2*MAG_BITS + 2*dtpn_pkg::OUT_FRAC + 2;
  // Remainder r = mag^2*2^60 - m^2*s, tracked with y = m*s (scaled).
  // Test bit b: (m+2^b)^2 s = m^2 s + 2^(b+1) m s + 2^(2b) s.
  logic [RW-1:0]      rem  [NB+1];
  logic [RW-1:0]      ms   [NB+1];
  logic [SQ_BITS-1:0] ss   [NB+1];
  logic [NB-1:0]      mm   [NB+1];
  logic [RW-1:0]      msq;

  always_ff @(posedge clk) begin
    if (en) begin
      msq    <= RW'(mag) * RW'(mag);
      ss[0]  <= sumsq;
    end
  end
  assign rem[0] = msq << (2*dtpn_pkg::OUT_FRAC);
  assign ms[0]  = '0;
  assign mm[0]  = '0;

  for (genvar i = 0; i < NB; i++) begin : g_bit
    localparam int B = NB - 1 - i;
    logic [RW:0] t;
    logic        ok;
    always_comb begin
      t  = ({1'b0, ms[i]} << (B+1)) + ({1'b0, RW'(ss[i])} << (2*B));
      ok = t <= {1'b0, rem[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= ok ? rem[i] - t[RW-1:0] : rem[i];
        ms[i+1]  <= ok ? ms[i] + (RW'(ss[i]) << B) : ms[i];
        mm[i+1]  <= ok ? (mm[i] | (NB'(1) << B)) : mm[i];
        ss[i+1]  <= ss[i];
      end
    end
  end
  assign m = mm[NB];
endmodule
`default_nettype wire
